@@ rtl/core/pfpr_pkg.sv @@
// Package for the parameter frame parser and responder.
// Frame codes, reply layout constants, register indexes and the job record.
// No dependencies.
package pfpr_pkg;

   localparam int FRAME_BYTES = 17;
   localparam int CNT_W       = 5;

   localparam logic [CNT_W-1:0] FRAME_CNT   = CNT_W'(FRAME_BYTES);
   localparam logic [CNT_W-1:0] FUN_CNT     = 5'd3;
   localparam logic [CNT_W-1:0] RD_CNT      = 5'd16;
   localparam logic [CNT_W-1:0] WR_CNT      = 5'd12;
   localparam logic [CNT_W-1:0] RD_LAST_IDX = 5'd16;
   localparam logic [CNT_W-1:0] WR_LAST_IDX = 5'd11;

   localparam logic [7:0] SOF_BYTE = 8'hAA;
   localparam logic [7:0] FUN_RD   = 8'hE0;
   localparam logic [7:0] FUN_WR   = 8'hE1;
   localparam logic [7:0] CMD_RD   = 8'hE1;
   localparam logic [7:0] FUN_RSP  = 8'hE1;
   localparam logic [7:0] LEN_RD   = 8'h0B;
   localparam logic [7:0] LEN_WR   = 8'h06;

   localparam logic [1:0] CSR_LAST_PARAM = 2'd0;
   localparam logic [1:0] CSR_SRC_ADDR   = 2'd1;
   localparam logic [1:0] CSR_TGT_ADDR   = 2'd2;

   localparam logic [15:0] LAST_PARAM_RST = 16'h0049;
   localparam logic [7:0]  SRC_ADDR_RST   = 8'h05;
   localparam logic [7:0]  TGT_ADDR_RST   = 8'hAF;

   typedef struct packed {
      logic        is_rd;
      logic [15:0] num;
      logic [31:0] wr_val;
      logic        rd_ok;
      logic        wf_off;
   } job_type;

endpackage

@@ rtl/core/param_frame_parser_responder_top.sv @@
// Top level of the parameter frame parser and responder.
// Holds the control registers; depends on pfpr_pkg, pfpr_parser and pfpr_reply.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   req     | req_valid, req_stall, req_rx_byte      | in
//   rsp     | rsp_valid, rsp_stall, rsp_tx_byte,     | out
//           | rsp_tx_last, rsp_waveform_off          |
//   csr     | csr_we, csr_index, csr_wdata           | in
//
// A new byte can follow every cycle while req_stall is low.
// A completed write frame, or read frame with CMD_RD, yields a 17-beat (read) or
// 12-beat (write) reply, one beat per cycle from the reply sequencer unless stalled;
// one further frame may complete while it drains.
// Reset is synchronous; the store's valid bits clear at once, so no clearing pass.
// rsp_stall holds the result register; req_stall rises only while a reply waits.
module param_frame_parser_responder_top #(
   parameter int NUM_SETS = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_tx_last,
   output logic        rsp_waveform_off,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [15:0] last_param_ff;
   logic [7:0]  src_addr_ff, tgt_addr_ff;

   logic              job_vld, job_take;
   pfpr_pkg::job_type job;
   logic [31:0]       rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_param_ff <= pfpr_pkg::LAST_PARAM_RST;
         src_addr_ff   <= pfpr_pkg::SRC_ADDR_RST;
         tgt_addr_ff   <= pfpr_pkg::TGT_ADDR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pfpr_pkg::CSR_LAST_PARAM: last_param_ff <= csr_wdata;
            pfpr_pkg::CSR_SRC_ADDR:   src_addr_ff   <= csr_wdata[7:0];
            pfpr_pkg::CSR_TGT_ADDR:   tgt_addr_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   pfpr_parser #(
      .NUM_SETS (NUM_SETS)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .last_param_number (last_param_ff),
      .job_take          (job_take),
      .job_vld           (job_vld),
      .job               (job),
      .rd_data           (rd_data)
   );

   pfpr_reply u_reply (
      .clock             (clock),
      .reset             (reset),
      .job_vld           (job_vld),
      .job               (job),
      .rd_data           (rd_data),
      .job_take          (job_take),
      .reply_source_addr (src_addr_ff),
      .reply_target_addr (tgt_addr_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_tx_last       (rsp_tx_last),
      .rsp_waveform_off  (rsp_waveform_off)
   );

endmodule

@@ rtl/core/pfpr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pfpr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 54
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pfpr_parser.sv @@
// Frame parser: byte buffer, byte count, waveform flag and the parameter store.
// Depends on pfpr_pkg and pfpr_ram.
module pfpr_parser #(
   parameter int NUM_SETS = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   input  logic [15:0]        last_param_number,
   input  logic               job_take,
   output logic               job_vld,
   output pfpr_pkg::job_type  job,
   output logic [31:0]        rd_data
);

   localparam int DEPTH  = 3 * NUM_SETS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [15:0] DEPTH_NUM = 16'(DEPTH);

   logic [7:0]                 buf_ff [pfpr_pkg::FRAME_BYTES];
   logic [7:0]                 buf_in [pfpr_pkg::FRAME_BYTES];
   logic [pfpr_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [pfpr_pkg::CNT_W-1:0] cnt_base, cnt_inc;
   logic                       wf_ff, wf_in;
   logic                       job_vld_ff, job_vld_in;
   pfpr_pkg::job_type          job_ff, job_in;
   logic [DEPTH-1:0]           vld_ff;

   logic              accept, store, rd_done, wr_done, rd_reply, in_range, wf_clr;
   logic [15:0]       num;
   logic [ADDR_W-1:0] addr;
   logic              ram_we, ram_re;

   assign accept    = req_valid && !req_stall;
   assign req_stall = job_vld_ff && !job_take;

   always_comb begin
      cnt_base = (req_rx_byte == pfpr_pkg::SOF_BYTE) ? '0 : cnt_ff;
      store    = cnt_base < pfpr_pkg::FRAME_CNT;
      cnt_inc  = store ? cnt_base + 5'd1 : cnt_base;
      buf_in   = buf_ff;
      if (store) begin
         buf_in[cnt_base] = req_rx_byte;
      end

      rd_done  = (buf_in[3] == pfpr_pkg::FUN_RD) && (cnt_inc >= pfpr_pkg::RD_CNT);
      wr_done  = !rd_done && (buf_in[3] == pfpr_pkg::FUN_WR) && (cnt_inc >= pfpr_pkg::WR_CNT);
      rd_reply = rd_done && (buf_in[5] == pfpr_pkg::CMD_RD);

      num      = rd_done ? {buf_in[6], buf_in[7]} : {buf_in[5], buf_in[6]};
      in_range = (num != 16'd0) && (num <= DEPTH_NUM);
      addr     = ADDR_W'(num - 16'd1);

      wf_clr = ((rd_reply && (num != 16'd0)) || wr_done) && (num >= last_param_number);
      if (wf_clr) begin
         wf_in = 1'b0;
      end else if (cnt_inc >= pfpr_pkg::FUN_CNT) begin
         wf_in = 1'b1;
      end else begin
         wf_in = wf_ff;
      end

      cnt_in = (rd_done || wr_done) ? '0 : cnt_inc;

      job_in.is_rd  = rd_done;
      job_in.num    = num;
      job_in.wr_val = {buf_in[7], buf_in[8], buf_in[9], buf_in[10]};
      job_in.rd_ok  = in_range && vld_ff[addr];
      job_in.wf_off = wf_in;

      if (accept && (rd_reply || wr_done)) begin
         job_vld_in = 1'b1;
      end else if (job_take) begin
         job_vld_in = 1'b0;
      end else begin
         job_vld_in = job_vld_ff;
      end

      ram_we = accept && wr_done && in_range;
      ram_re = accept && rd_reply && in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         wf_ff      <= 1'b0;
         job_vld_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         job_vld_ff <= job_vld_in;
         if (accept) begin
            cnt_ff <= cnt_in;
            wf_ff  <= wf_in;
         end
         if (ram_we) begin
            vld_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         buf_ff <= buf_in;
      end
      if (accept && (rd_reply || wr_done)) begin
         job_ff <= job_in;
      end
   end

   pfpr_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr),
      .wr_data (job_in.wr_val),
      .rd_en   (ram_re),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign job_vld = job_vld_ff;
   assign job     = job_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= pfpr_pkg::FRAME_CNT)
      else $error("byte count beyond frame length");

   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      job_vld_ff && !job_take |=> job_vld_ff && $stable(job_ff))
      else $error("pending job changed before hand-off");

endmodule

@@ rtl/core/pfpr_reply.sv @@
// Reply sequencer: walks one reply frame a beat per cycle unless stalled,
// adds the checksum, and holds the result register. Depends on pfpr_pkg.
module pfpr_reply (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_vld,
   input  pfpr_pkg::job_type job,
   input  logic [31:0]       rd_data,
   output logic              job_take,
   input  logic [7:0]        reply_source_addr,
   input  logic [7:0]        reply_target_addr,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_tx_last,
   output logic              rsp_waveform_off
);

   logic                       busy_ff, busy_in;
   logic [pfpr_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic [7:0]                 sum_ff, sum_in;
   logic                       is_rd_ff;
   logic [15:0]                num_ff;
   logic [31:0]                val_ff;
   logic                       wf_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_byte_ff;
   logic                       rsp_last_ff, rsp_wf_ff;

   logic       out_free, emit, is_last;
   logic [7:0] cur_byte;
   logic [31:0] take_val;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      emit     = busy_ff && out_free;
      is_last  = idx_ff == (is_rd_ff ? pfpr_pkg::RD_LAST_IDX : pfpr_pkg::WR_LAST_IDX);
      job_take = job_vld && (!busy_ff || (emit && is_last));
      take_val = job.is_rd ? (job.rd_ok ? rd_data : 32'd0) : job.wr_val;

      if (is_last) begin
         cur_byte = sum_ff;
      end else begin
         unique case (idx_ff)
            5'd0:    cur_byte = pfpr_pkg::SOF_BYTE;
            5'd1:    cur_byte = reply_source_addr;
            5'd2:    cur_byte = reply_target_addr;
            5'd3:    cur_byte = pfpr_pkg::FUN_RSP;
            5'd4:    cur_byte = is_rd_ff ? pfpr_pkg::LEN_RD : pfpr_pkg::LEN_WR;
            5'd5:    cur_byte = num_ff[15:8];
            5'd6:    cur_byte = num_ff[7:0];
            5'd7:    cur_byte = val_ff[31:24];
            5'd8:    cur_byte = val_ff[23:16];
            5'd9:    cur_byte = val_ff[15:8];
            5'd10:   cur_byte = val_ff[7:0];
            default: cur_byte = 8'd0;
         endcase
      end

      busy_in = busy_ff;
      idx_in  = idx_ff;
      sum_in  = sum_ff;
      if (job_take) begin
         busy_in = 1'b1;
         idx_in  = '0;
         sum_in  = 8'd0;
      end else if (emit) begin
         busy_in = !is_last;
         idx_in  = idx_ff + 5'd1;
         sum_in  = sum_ff + cur_byte;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      if (job_take) begin
         is_rd_ff <= job.is_rd;
         num_ff   <= job.num;
         val_ff   <= take_val;
         wf_ff    <= job.wf_off;
      end
      if (emit) begin
         rsp_byte_ff <= cur_byte;
         rsp_last_ff <= is_last;
         rsp_wf_ff   <= wf_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_byte      = rsp_byte_ff;
   assign rsp_tx_last      = rsp_last_ff;
   assign rsp_waveform_off = rsp_wf_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= pfpr_pkg::RD_LAST_IDX)
      else $error("reply index past frame end");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      emit && is_last && !job_take |=> !busy_ff && rsp_valid && rsp_tx_last)
      else $error("sequencer did not close frame on checksum beat");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      job_take |=> busy_ff && idx_ff == '0 && sum_ff == 8'd0)
      else $error("new reply frame not started cleanly");

endmodule

@@ sim/param_frame_parser_responder_top_tb.sv @@
// Self-checking testbench for param_frame_parser_responder_top: feeds link bytes and
// checks every reply beat against a behavioural model of the parser and its store.
// Depends on pfpr_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module param_frame_parser_responder_top_tb;

   localparam int NUM_SETS       = 18;
   localparam int STORE_DEPTH    = 3 * NUM_SETS;
   localparam int RD_REPLY_BEATS = 17;
   localparam int WR_REPLY_BEATS = 12;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ERR_SHOWN      = 10;
   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       tx_last;
      logic       wf_off;
   } reply_beat_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        rsp_waveform_off;
   logic        csr_we      = 1'b0;
   logic [1:0]  csr_index   = pfpr_pkg::CSR_LAST_PARAM;
   logic [15:0] csr_wdata   = 16'h0000;

   param_frame_parser_responder_top #(.NUM_SETS(NUM_SETS)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_tx_last      (rsp_tx_last),
      .rsp_waveform_off (rsp_waveform_off),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // parser model state
   logic [7:0]  frm_m   [pfpr_pkg::FRAME_BYTES] = '{default: 8'h00};
   logic [4:0]  cnt_m   = '0;
   logic [31:0] store_m [STORE_DEPTH] = '{default: 32'h0};
   logic        wf_m    = 1'b0;
   logic [15:0] thr_m   = pfpr_pkg::LAST_PARAM_RST;
   logic [7:0]  src_m   = pfpr_pkg::SRC_ADDR_RST;
   logic [7:0]  tgt_m   = pfpr_pkg::TGT_ADDR_RST;

   logic [7:0]     rx_bytes_q [$];
   reply_beat_type reply_beats_q [$];
   int             bytes_issued = 0;
   int             bytes_taken  = 0;
   int             errors       = 0;
   int             gap_left     = 0;
   int             stall_left   = 0;
   int             idle_cycles  = 0;
   logic           calm_tail    = 1'b0;
   reply_beat_type beat_seen, beat_want;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic note_error(input string msg);
      errors++;
      if (errors <= ERR_SHOWN)
         $display("%s", msg);
   endtask

   // One received byte through the parser; queues whatever reply it completes.
   task automatic take_rx_byte(input logic [7:0] b);
      logic [7:0]     rep [pfpr_pkg::FRAME_BYTES];
      logic [15:0]    num;
      logic [31:0]    val;
      logic [7:0]     sum;
      reply_beat_type beat;
      int             len;
      int             k;
      len = 0;
      for (k = 0; k < pfpr_pkg::FRAME_BYTES; k++)
         rep[k] = 8'h00;
      if (b == pfpr_pkg::SOF_BYTE)
         cnt_m = '0;
      if (cnt_m < pfpr_pkg::FRAME_CNT) begin
         frm_m[cnt_m] = b;
         cnt_m = cnt_m + 1'b1;
      end
      if (cnt_m >= pfpr_pkg::FUN_CNT) begin
         wf_m = 1'b1;
         if (frm_m[3] == pfpr_pkg::FUN_RD && cnt_m >= pfpr_pkg::RD_CNT) begin
            num   = {frm_m[6], frm_m[7]};
            cnt_m = '0;
            if (frm_m[5] == pfpr_pkg::CMD_RD) begin
               len = RD_REPLY_BEATS;
               rep[4] = pfpr_pkg::LEN_RD;
               if (num != 0) begin
                  rep[5] = num[15:8];
                  rep[6] = num[7:0];
                  if (num <= STORE_DEPTH)
                     {rep[7], rep[8], rep[9], rep[10]} = store_m[num - 1];
                  if (num >= thr_m)
                     wf_m = 1'b0;
               end
            end
         end else if (frm_m[3] == pfpr_pkg::FUN_WR && cnt_m >= pfpr_pkg::WR_CNT) begin
            num   = {frm_m[5], frm_m[6]};
            val   = {frm_m[7], frm_m[8], frm_m[9], frm_m[10]};
            cnt_m = '0;
            if (num != 0 && num <= STORE_DEPTH)
               store_m[num - 1] = val;
            len = WR_REPLY_BEATS;
            rep[4] = pfpr_pkg::LEN_WR;
            rep[5] = num[15:8];
            rep[6] = num[7:0];
            {rep[7], rep[8], rep[9], rep[10]} = val;
            if (num >= thr_m)
               wf_m = 1'b0;
         end
      end
      if (len > 0) begin
         rep[0] = pfpr_pkg::SOF_BYTE;
         rep[1] = src_m;
         rep[2] = tgt_m;
         rep[3] = pfpr_pkg::FUN_RSP;
         sum = 8'h00;
         for (k = 0; k < len - 1; k++)
            sum = sum + rep[k];
         rep[len - 1] = sum;
         for (k = 0; k < len; k++) begin
            beat.tx_byte = rep[k];
            beat.tx_last = (k == len - 1);
            beat.wf_off  = wf_m;
            reply_beats_q.push_back(beat);
         end
      end
   endtask

   // ---------------- stimulus helpers ----------------

   task automatic push_rx(input logic [7:0] b);
      rx_bytes_q.push_back(b);
      bytes_issued++;
   endtask

   // any byte but the start-of-frame code
   function automatic logic [7:0] rand_body();
      logic [7:0] r;
      r = 8'($urandom_range(0, 254));
      if (r >= pfpr_pkg::SOF_BYTE)
         r = r + 1'b1;
      return r;
   endfunction

   function automatic logic [15:0] pick_num();
      case ($urandom_range(0, 11))
         0: return 16'd0;
         1: return 16'(STORE_DEPTH);
         2: return 16'(STORE_DEPTH + 1);
         3: return 16'hFFFF;
         4: return thr_m;
         5: return thr_m - 1'b1;
         6: return 16'($urandom);
         7: return 16'($urandom_range(1, STORE_DEPTH));
         default: return 16'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return {rand_body(), rand_body(), rand_body(), rand_body()};
      endcase
   endfunction

   // keep < frame length gives a truncated frame
   task automatic send_read(input logic [7:0] lead, input logic [15:0] num,
                            input logic [7:0] cmd, input int keep);
      logic [7:0] f [16];
      int k;
      f[0] = lead;
      f[1] = rand_body();
      f[2] = rand_body();
      f[3] = pfpr_pkg::FUN_RD;
      f[4] = rand_body();
      f[5] = cmd;
      f[6] = num[15:8];
      f[7] = num[7:0];
      for (k = 8; k < 16; k++)
         f[k] = rand_body();
      for (k = 0; k < keep && k < 16; k++)
         push_rx(f[k]);
   endtask

   task automatic send_write(input logic [7:0] lead, input logic [15:0] num,
                             input logic [31:0] val, input int keep);
      logic [7:0] f [12];
      int k;
      f[0]  = lead;
      f[1]  = rand_body();
      f[2]  = rand_body();
      f[3]  = pfpr_pkg::FUN_WR;
      f[4]  = rand_body();
      f[5]  = num[15:8];
      f[6]  = num[7:0];
      f[7]  = val[31:24];
      f[8]  = val[23:16];
      f[9]  = val[15:8];
      f[10] = val[7:0];
      f[11] = rand_body();
      for (k = 0; k < keep && k < 12; k++)
         push_rx(f[k]);
   endtask

   // unknown function code, run past the buffer end
   task automatic send_overlong(input int extra);
      logic [7:0] fun;
      int k;
      do
         fun = rand_body();
      while (fun == pfpr_pkg::FUN_RD || fun == pfpr_pkg::FUN_WR);
      push_rx(pfpr_pkg::SOF_BYTE);
      push_rx(rand_body());
      push_rx(rand_body());
      push_rx(fun);
      for (k = 0; k < extra; k++)
         push_rx(rand_body());
   endtask

   task automatic queue_random_sequence();
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 34)
         send_write(pfpr_pkg::SOF_BYTE, pick_num(), pick_value(), WR_REPLY_BEATS);
      else if (r < 68)
         send_read(pfpr_pkg::SOF_BYTE, pick_num(), pfpr_pkg::CMD_RD, 16);
      else if (r < 74)
         send_read(pfpr_pkg::SOF_BYTE, pick_num(), rand_body(), 16);
      else if (r < 78)
         send_write(pfpr_pkg::SOF_BYTE, pick_num(), pick_value(), $urandom_range(1, 11));
      else if (r < 82)
         send_read(pfpr_pkg::SOF_BYTE, pick_num(), pfpr_pkg::CMD_RD, $urandom_range(1, 15));
      else if (r < 88) begin
         for (k = $urandom_range(1, 6); k > 0; k--)
            push_rx(8'($urandom_range(0, 255)));
      end else if (r < 94)
         send_overlong($urandom_range(14, 22));
      else
         send_write(rand_body(), pick_num(), pick_value(), WR_REPLY_BEATS);
   endtask

   // hold until every byte is taken and every reply beat has come back
   task automatic drain();
      while (bytes_taken != bytes_issued || reply_beats_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_random(input int min_bytes);
      int start;
      start = bytes_issued;
      while (bytes_issued - start < min_bytes)
         queue_random_sequence();
      drain();
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         pfpr_pkg::CSR_LAST_PARAM: thr_m = data;
         pfpr_pkg::CSR_SRC_ADDR:   src_m = data[7:0];
         pfpr_pkg::CSR_TGT_ADDR:   tgt_m = data[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            take_rx_byte(req_rx_byte);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_bytes_q.size() != 0) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_q.pop_front();
               if (!calm_tail && $urandom_range(0, 9) == 0)
                  gap_left = $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            beat_seen = '{rsp_tx_byte, rsp_tx_last, rsp_waveform_off};
            if (reply_beats_q.size() == 0) begin
               note_error($sformatf("%0t: unexpected beat byte %02h last %0b wf %0b",
                                    $time, rsp_tx_byte, rsp_tx_last, rsp_waveform_off));
            end else begin
               beat_want = reply_beats_q.pop_front();
               if (beat_seen !== beat_want)
                  note_error($sformatf(
                     "%0t: beat want byte %02h last %0b wf %0b, got %02h %0b %0b",
                     $time, beat_want.tx_byte, beat_want.tx_last, beat_want.wf_off,
                     beat_seen.tx_byte, beat_seen.tx_last, beat_seen.wf_off));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm_tail && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // cycles with no expected beat moving on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || csr_we ||
          (rsp_valid && !rsp_stall && reply_beats_q.size() != 0)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // ---------------- test sequence ----------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed frames under reset register values
      send_read(pfpr_pkg::SOF_BYTE, 16'd0, pfpr_pkg::CMD_RD, 16);
      send_write(pfpr_pkg::SOF_BYTE, 16'd1, 32'hFFFF_FFFF, WR_REPLY_BEATS);
      send_read(pfpr_pkg::SOF_BYTE, 16'd1, pfpr_pkg::CMD_RD, 16);
      send_read(pfpr_pkg::SOF_BYTE, pfpr_pkg::LAST_PARAM_RST, pfpr_pkg::CMD_RD, 16);
      send_write(pfpr_pkg::SOF_BYTE, 16'd2, 32'h5555_5555, 7);     // cut short, restarted
      send_overlong(14);
      drain();

      csr_write(pfpr_pkg::CSR_LAST_PARAM, 16'h0000);
      csr_write(pfpr_pkg::CSR_SRC_ADDR, 16'h0000);
      csr_write(pfpr_pkg::CSR_TGT_ADDR, 16'hA5FF);   // upper bits are not part of the register
      csr_write(CSR_SPARE, 16'hBEEF);
      run_random(10);

      csr_write(pfpr_pkg::CSR_LAST_PARAM, 16'($urandom_range(1, STORE_DEPTH + 6)));
      csr_write(pfpr_pkg::CSR_SRC_ADDR, 16'($urandom));
      csr_write(pfpr_pkg::CSR_TGT_ADDR, 16'($urandom));
      calm_tail = 1'b1;
      run_random(10);

      if (reply_beats_q.size() != 0)
         note_error($sformatf("%0d reply beats never arrived", reply_beats_q.size()));
      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
